[rtl/line_hash_whitespace_modes_defines.svh]
// assertion macros for the line hash block
`ifndef LINE_HASH_WHITESPACE_MODES_DEFINES_SVH
`define LINE_HASH_WHITESPACE_MODES_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LHWS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lhws assertion failed");

// next-cycle implication, checked out of reset
`define LHWS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lhws assertion failed");

`endif

[rtl/lhws_pkg.sv]
// types and constants of the line hash block
`timescale 1ns / 1ps

package lhws_pkg;

    localparam int unsigned MODE_W    = 2;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned HASH_SEED = 5381;
    localparam int unsigned MIX_SHIFT = 5;

    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_TAB     = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_CR      = 8'h0D;

    typedef enum logic [MODE_W-1:0] {
        WS_HASH_ALL   = 2'd0,
        WS_IGNORE_ALL = 2'd1,
        WS_COLLAPSE   = 2'd2,
        WS_IGNORE_EOL = 2'd3
    } t_ws_mode;

    function automatic logic is_ws(input logic [BYTE_W-1:0] b);
        is_ws = (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
    endfunction

endpackage

[rtl/line_hash_whitespace_modes.sv]
// top level: per-line multiply-by-33 xor hash of a byte stream with whitespace modes
`timescale 1ns / 1ps

// Takes one byte per clock and returns one hash per line record, ending at a newline
// or at a byte flagged end_of_data. A byte passes an input register, then the hash
// update (multiply by 33 as shift-add, xor with the sign-extended byte) runs into
// the line state and, at a record end, into the result register. Throughput is one
// byte per clock, set by the update loop on the committed hash. The input side
// stalls only when a record-ending byte meets a full, unaccepted result register.
// The user must write the whitespace mode through the configuration channel only
// while the block is idle; the block itself does not enforce this. The hash width
// follows HASH_WIDTH (32 to 64).
module line_hash_whitespace_modes #(
    parameter int unsigned HASH_WIDTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [lhws_pkg::BYTE_W-1:0]   i_byte_in,
    input  logic                          i_end_of_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [HASH_WIDTH-1:0]         o_line_hash,
    output logic                          o_had_newline,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lhws_pkg::MODE_W-1:0]   i_cfg_data
);
    import lhws_pkg::*;

    `include "line_hash_whitespace_modes_defines.svh"

    localparam logic [HASH_WIDTH-1:0] LP_SEED = HASH_WIDTH'(HASH_SEED);

    function automatic logic [HASH_WIDTH-1:0] mix(input logic [HASH_WIDTH-1:0] h,
                                                  input logic [BYTE_W-1:0]     b);
        logic [HASH_WIDTH-1:0] v;
        v   = {{(HASH_WIDTH-BYTE_W){b[BYTE_W-1]}}, b};
        mix = (h + (h << MIX_SHIFT)) ^ v;
    endfunction

    t_ws_mode              r_mode;
    logic                  r_in_valid;
    logic [BYTE_W-1:0]     r_byte;
    logic                  r_eod;
    logic [HASH_WIDTH-1:0] r_comm, n_comm;
    logic [HASH_WIDTH-1:0] r_tent, n_tent;
    logic                  r_pend, n_pend;
    logic                  r_out_valid;
    logic [HASH_WIDTH-1:0] r_out_hash;
    logic                  r_out_nl;

    logic                  w_nl;
    logic                  w_ws;
    logic                  w_emit;
    logic                  w_fire;
    logic [HASH_WIDTH-1:0] w_base;

    assign w_nl       = (r_byte == CHAR_NEWLINE);
    assign w_ws       = is_ws(r_byte);
    assign w_emit     = w_nl || r_eod;
    assign w_fire     = r_in_valid && (!w_emit || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid   = r_out_valid;
    assign o_line_hash   = r_out_hash;
    assign o_had_newline = r_out_nl;

    // line state update for the byte in the input register
    always_comb begin
        n_comm = r_comm;
        n_tent = r_tent;
        n_pend = r_pend;
        w_base = r_comm;
        if (!w_nl) begin
            if (r_mode == WS_HASH_ALL) begin
                n_comm = mix(r_comm, r_byte);
            end else if (w_ws) begin
                if (r_mode == WS_IGNORE_EOL) begin
                    n_tent = mix(r_pend ? r_tent : r_comm, r_byte);
                end
                if (r_mode != WS_IGNORE_ALL) begin
                    n_pend = 1'b1;
                end
            end else begin
                if (r_pend) begin
                    priority if (r_mode == WS_COLLAPSE) begin
                        w_base = mix(r_comm, CHAR_SPACE);
                    end else if (r_mode == WS_IGNORE_EOL) begin
                        w_base = r_tent;
                    end else begin
                        w_base = r_comm;
                    end
                end
                n_comm = mix(w_base, r_byte);
                n_pend = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= WS_HASH_ALL;
            r_in_valid  <= 1'b0;
            r_comm      <= LP_SEED;
            r_tent      <= LP_SEED;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= t_ws_mode'(i_cfg_data);
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_fire) begin
                if (w_emit) begin
                    r_comm <= LP_SEED;
                    r_tent <= LP_SEED;
                    r_pend <= 1'b0;
                end else begin
                    r_comm <= n_comm;
                    r_tent <= n_tent;
                    r_pend <= n_pend;
                end
            end
            if (w_fire && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_byte <= i_byte_in;
            r_eod  <= i_end_of_data;
        end
        if (w_fire && w_emit) begin
            r_out_hash <= n_comm;
            r_out_nl   <= w_nl;
        end
    end

    `LHWS_ASSERT_NEXT(a_line_cleared, w_fire && w_emit, !r_pend && (r_comm == LP_SEED) && (r_tent == LP_SEED))
    `LHWS_ASSERT_NEXT(a_result_loaded, w_fire && w_emit, r_out_valid)
    `LHWS_ASSERT_NEXT(a_run_opens, w_fire && w_ws && !w_emit && ((r_mode == WS_COLLAPSE) || (r_mode == WS_IGNORE_EOL)), r_pend)
    `LHWS_ASSERT_NEXT(a_item_held, r_in_valid && !w_fire, r_in_valid && $stable(r_byte) && $stable(r_eod))
    `LHWS_ASSERT_NOW(a_stall_cause, r_in_valid && !w_fire, w_emit && r_out_valid && !i_out_ready)

endmodule
